### rtl/core/rfo_pkg.sv
// shared types, constants and code word tables for the outlet transmitter
// no dependencies
package rfo_pkg;

	localparam int CODE_BITS  = 25;
	localparam int ROM_DEPTH  = 5;
	localparam int WIDTH_BITS = 16;
	localparam int REP_BITS   = 8;
	localparam int POS_BITS   = 5;
	localparam int OUTLET_W   = 3;
	localparam int CFG_IDX_W  = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SHORT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 2'd3;

	// register reset values
	localparam logic [WIDTH_BITS-1:0] SHORT_RST  = 16'd160;
	localparam logic [WIDTH_BITS-1:0] LONG_RST   = 16'd520;
	localparam logic [WIDTH_BITS-1:0] GAP_RST    = 16'd5620;
	localparam logic [REP_BITS-1:0]   REPEAT_RST = 8'd10;

	// code words, most significant bit sent first
	localparam logic [CODE_BITS-1:0] ROM_ON [ROM_DEPTH] = '{
		25'h1F55599, 25'h1F55459, 25'h1F551D9, 25'h1F545D9, 25'h1F45559
	};
	localparam logic [CODE_BITS-1:0] ROM_OFF [ROM_DEPTH] = '{
		25'h1F55587, 25'h1F55447, 25'h1F551C7, 25'h1F545C7, 25'h1F45547
	};

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HIGH,
		PH_LOW,
		PH_GAP
	} phase_t;

	typedef enum logic [1:0] {
		ST_TICK,
		ST_STARTED,
		ST_SKIPPED,
		ST_REJECTED
	} status_t;

	localparam logic CMD_TICK    = 1'b0;
	localparam logic CMD_REQUEST = 1'b1;

	typedef struct packed {
		logic [WIDTH_BITS-1:0] short_width;
		logic [WIDTH_BITS-1:0] long_width;
		logic [WIDTH_BITS-1:0] gap_width;
		logic [REP_BITS-1:0]   repeat_total;
	} cfg_t;

	typedef struct packed {
		logic    pin_level;
		logic    busy_res;
		status_t request_status;
	} result_t;

endpackage

### rtl/core/rfo_cfg_regs.sv
// configuration register file for the outlet transmitter
// depends on rfo_pkg
module rfo_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [rfo_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rfo_pkg::WIDTH_BITS-1:0] cfg_wdata,
	output rfo_pkg::cfg_t                  cfg
);
	import rfo_pkg::*;

	cfg_t cfg_q;

	// write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_width  <= SHORT_RST;
			cfg_q.long_width   <= LONG_RST;
			cfg_q.gap_width    <= GAP_RST;
			cfg_q.repeat_total <= REPEAT_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_SHORT:  cfg_q.short_width  <= cfg_wdata;
				REG_LONG:   cfg_q.long_width   <= cfg_wdata;
				REG_GAP:    cfg_q.gap_width    <= cfg_wdata;
				REG_REPEAT: cfg_q.repeat_total <= cfg_wdata[REP_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/rfo_encoder.sv
// pulse timer, bit sequencer and outlet state memory
// depends on rfo_pkg
module rfo_encoder #(
	parameter int NUM_OUTLETS = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic                         command,
	input  logic [rfo_pkg::OUTLET_W-1:0] outlet,
	input  logic                         switch_on,
	input  rfo_pkg::cfg_t                cfg,
	output rfo_pkg::result_t             result
);
	import rfo_pkg::*;

	localparam int OIDX_W = (NUM_OUTLETS > 1) ? $clog2(NUM_OUTLETS) : 1;
	localparam logic [OUTLET_W-1:0] OUTLET_LIM = OUTLET_W'(NUM_OUTLETS);
	localparam logic [POS_BITS-1:0] LAST_POS   = POS_BITS'(CODE_BITS - 1);

	phase_t                phase_q, phase_d;
	logic [CODE_BITS-1:0]  word_q, word_d;
	logic [POS_BITS-1:0]   pos_q, pos_d;
	logic [REP_BITS-1:0]   rep_q, rep_d;
	logic [WIDTH_BITS-1:0] ticks_q, ticks_d;
	logic                  known_q [NUM_OUTLETS];
	logic                  on_q    [NUM_OUTLETS];

	logic [POS_BITS-1:0]   pos_clamp;
	logic                  cur_bit;
	logic [WIDTH_BITS-1:0] phase_len;
	logic [WIDTH_BITS:0]   elapsed;
	logic [REP_BITS:0]     rep_next;
	logic [OIDX_W-1:0]     oidx;
	logic                  in_range;
	logic                  start;
	status_t               req_status;

	// current bit and length of the running phase
	always_comb begin
		pos_clamp = (pos_q > LAST_POS) ? LAST_POS : pos_q;
		cur_bit   = word_q[LAST_POS - pos_clamp];
		case (phase_q)
			PH_HIGH: phase_len = cur_bit ? cfg.short_width : cfg.long_width;
			PH_LOW:  phase_len = cur_bit ? cfg.long_width : cfg.short_width;
			default: phase_len = cfg.gap_width;
		endcase
		elapsed  = {1'b0, ticks_q} + 1'b1;
		rep_next = {1'b0, rep_q} + 1'b1;
	end

	// request decision
	always_comb begin
		oidx       = outlet[OIDX_W-1:0];
		in_range   = (outlet < OUTLET_LIM);
		start      = 1'b0;
		req_status = ST_SKIPPED;
		if (phase_q != PH_IDLE) begin
			req_status = ST_REJECTED;
		end else if (in_range) begin
			if (!known_q[oidx] || (on_q[oidx] != switch_on)) begin
				start      = 1'b1;
				req_status = ST_STARTED;
			end
		end
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		word_d  = word_q;
		pos_d   = pos_q;
		rep_d   = rep_q;
		ticks_d = ticks_q;
		if (command == CMD_REQUEST) begin
			if (start) begin
				word_d  = switch_on ? ROM_ON[outlet] : ROM_OFF[outlet];
				pos_d   = '0;
				rep_d   = '0;
				ticks_d = '0;
				phase_d = PH_HIGH;
			end
		end else if (phase_q != PH_IDLE) begin
			if (elapsed < {1'b0, phase_len}) begin
				ticks_d = elapsed[WIDTH_BITS-1:0];
			end else begin
				ticks_d = '0;
				unique case (phase_q)
					PH_HIGH: phase_d = PH_LOW;
					PH_LOW: begin
						if (pos_q >= LAST_POS) begin
							pos_d   = '0;
							phase_d = PH_GAP;
						end else begin
							pos_d   = pos_q + 1'b1;
							phase_d = PH_HIGH;
						end
					end
					PH_GAP: begin
						if (rep_next >= {1'b0, cfg.repeat_total}) begin
							rep_d   = '0;
							phase_d = PH_IDLE;
						end else begin
							rep_d   = rep_next[REP_BITS-1:0];
							phase_d = PH_HIGH;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// result of this request
	always_comb begin
		if (command == CMD_TICK) begin
			result.pin_level      = (phase_q == PH_HIGH);
			result.busy_res       = (phase_q != PH_IDLE);
			result.request_status = ST_TICK;
		end else begin
			result.pin_level      = start || (phase_q == PH_HIGH);
			result.busy_res       = start || (phase_q != PH_IDLE);
			result.request_status = req_status;
		end
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			word_q  <= '0;
			pos_q   <= '0;
			rep_q   <= '0;
			ticks_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			word_q  <= word_d;
			pos_q   <= pos_d;
			rep_q   <= rep_d;
			ticks_q <= ticks_d;
		end
	end

	// remembered outlet states, unknown until first started request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_OUTLETS; i++) begin
				known_q[i] <= 1'b0;
			end
		end else if (fire && (command == CMD_REQUEST) && start) begin
			known_q[oidx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && (command == CMD_REQUEST) && start) begin
			on_q[oidx] <= switch_on;
		end
	end

endmodule

### rtl/core/rf_outlet_pulse_width_transmitter_top.sv
// top level of the outlet transmitter: input stage, encoder, result stage
// depends on rfo_pkg, rfo_cfg_regs, rfo_encoder
//
//   channel   handshake             payload
//   in        in_valid / in_ready   command, outlet, switch_on
//   out       out_valid / out_ready pin_level, busy_res, request_status
//   cfg       cfg_wen               cfg_index, cfg_wdata
//
// one request per cycle sustained while the result stage is not stalled
// the input stage feeds the encoder, which updates its state as the request
// moves into the result stage
// a stalled result holds the result stage and, behind it, the input stage
// reset clears all sequencer state and marks every outlet state unknown
module rf_outlet_pulse_width_transmitter_top #(
	parameter int NUM_OUTLETS = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           command,
	input  logic [rfo_pkg::OUTLET_W-1:0]   outlet,
	input  logic                           switch_on,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           pin_level,
	output logic                           busy_res,
	output logic [1:0]                     request_status,
	input  logic                           cfg_wen,
	input  logic [rfo_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rfo_pkg::WIDTH_BITS-1:0] cfg_wdata
);
	import rfo_pkg::*;

	cfg_t                cfg;
	result_t             result;
	result_t             result_s2;
	logic                valid_s1, valid_s2;
	logic                command_s1, switch_on_s1;
	logic [OUTLET_W-1:0] outlet_s1;
	logic                adv_s1;

	// handshake flow
	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	rfo_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	rfo_encoder #(
		.NUM_OUTLETS (NUM_OUTLETS)
	) u_enc (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (adv_s1),
		.command   (command_s1),
		.outlet    (outlet_s1),
		.switch_on (switch_on_s1),
		.cfg       (cfg),
		.result    (result)
	);

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			command_s1   <= command;
			outlet_s1    <= outlet;
			switch_on_s1 <= switch_on;
		end
	end

	// result stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// result stage payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= result;
		end
	end

	assign out_valid      = valid_s2;
	assign pin_level      = result_s2.pin_level;
	assign busy_res       = result_s2.busy_res;
	assign request_status = result_s2.request_status;

endmodule

### tb/tb_rf_outlet_pulse_width_transmitter_top.sv
// self-checking testbench for the outlet code transmitter: random requests and ticks,
// per-field compare against an in-bench encoder, register changes while quiet
// depends on rfo_pkg and rf_outlet_pulse_width_transmitter_top
module tb_rf_outlet_pulse_width_transmitter_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rfo_pkg::*;

	localparam int NUM_OUTLETS = 5;
	localparam int RANDOM_ITEMS = 700;

	// remembered outlet levels
	localparam logic [1:0] LEVEL_OFF     = 2'd0;
	localparam logic [1:0] LEVEL_ON      = 2'd1;
	localparam logic [1:0] LEVEL_UNKNOWN = 2'd2;

	typedef struct packed {
		logic                command;
		logic [OUTLET_W-1:0] outlet;
		logic                switch_on;
	} switch_item_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  command = CMD_TICK;
	logic [OUTLET_W-1:0]   outlet = '0;
	logic                  switch_on = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  pin_level;
	logic                  busy_res;
	logic [1:0]            request_status;
	logic                  cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_SHORT;
	logic [WIDTH_BITS-1:0] cfg_wdata = '0;

	// encoder state kept by the bench
	cfg_t                 reg_file;
	logic [1:0]           outlet_level [NUM_OUTLETS];
	logic [CODE_BITS-1:0] word_bits;
	logic [POS_BITS-1:0]  bit_idx;
	logic [REP_BITS-1:0]  words_sent;
	phase_t               tx_phase;
	logic [WIDTH_BITS-1:0] tx_ticks;

	switch_item_t switch_items [$];
	result_t      pin_results_due [$];
	switch_item_t offered;
	int           queued_total = 0;
	int           items_taken = 0;
	int           results_taken = 0;
	int           errors = 0;
	int           status_seen [4] = '{0, 0, 0, 0};
	int           busy_ticks = 0;
	int           stall_left = 0;
	bit           stall_done = 1'b0;

	rf_outlet_pulse_width_transmitter_top #(
		.NUM_OUTLETS(NUM_OUTLETS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.outlet(outlet),
		.switch_on(switch_on),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pin_level(pin_level),
		.busy_res(busy_res),
		.request_status(request_status),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// bit being sent, clamped to the last one
	function automatic logic code_bit_now();
		int pos;
		pos = (bit_idx >= CODE_BITS) ? CODE_BITS - 1 : int'(bit_idx);
		return word_bits[CODE_BITS-1-pos];
	endfunction

	function automatic int phase_span();
		if (tx_phase == PH_HIGH)
			return code_bit_now() ? int'(reg_file.short_width) :
				int'(reg_file.long_width);
		if (tx_phase == PH_LOW)
			return code_bit_now() ? int'(reg_file.long_width) :
				int'(reg_file.short_width);
		return int'(reg_file.gap_width);
	endfunction

	// one microsecond of pulse timing
	function automatic void advance_pulse_timer();
		if (int'(tx_ticks) + 1 < phase_span()) begin
			tx_ticks = tx_ticks + 1'b1;
			return;
		end
		tx_ticks = '0;
		case (tx_phase)
			PH_HIGH: begin
				tx_phase = PH_LOW;
			end
			PH_LOW: begin
				bit_idx = bit_idx + 1'b1;
				if (bit_idx >= CODE_BITS) begin
					bit_idx = '0;
					tx_phase = PH_GAP;
				end else begin
					tx_phase = PH_HIGH;
				end
			end
			default: begin
				words_sent = words_sent + 1'b1;
				if (words_sent >= reg_file.repeat_total) begin
					words_sent = '0;
					tx_phase = PH_IDLE;
				end else begin
					tx_phase = PH_HIGH;
				end
			end
		endcase
	endfunction

	// expected result of one accepted request, updating the encoder state
	function automatic result_t pin_step(switch_item_t it);
		result_t r;
		r.request_status = ST_TICK;
		if (it.command == CMD_TICK) begin
			r.busy_res = (tx_phase != PH_IDLE);
			r.pin_level = (tx_phase == PH_HIGH);
			if (r.busy_res)
				advance_pulse_timer();
		end else begin
			if (tx_phase != PH_IDLE) begin
				r.request_status = ST_REJECTED;
			end else if (it.outlet >= NUM_OUTLETS) begin
				r.request_status = ST_SKIPPED;
			end else if (outlet_level[it.outlet] ==
				(it.switch_on ? LEVEL_ON : LEVEL_OFF)) begin
				r.request_status = ST_SKIPPED;
			end else begin
				outlet_level[it.outlet] = it.switch_on ? LEVEL_ON : LEVEL_OFF;
				word_bits = it.switch_on ? ROM_ON[it.outlet] : ROM_OFF[it.outlet];
				bit_idx = '0;
				words_sent = '0;
				tx_ticks = '0;
				tx_phase = PH_HIGH;
				r.request_status = ST_STARTED;
			end
			r.busy_res = (tx_phase != PH_IDLE);
			r.pin_level = (tx_phase == PH_HIGH);
		end
		return r;
	endfunction

	// ticks for one full transmission under the current registers
	function automatic int word_run_ticks();
		int s, l, g, n;
		s = (reg_file.short_width == 0) ? 1 : int'(reg_file.short_width);
		l = (reg_file.long_width == 0) ? 1 : int'(reg_file.long_width);
		g = (reg_file.gap_width == 0) ? 1 : int'(reg_file.gap_width);
		n = (reg_file.repeat_total == 0) ? 1 : int'(reg_file.repeat_total);
		return (CODE_BITS * (s + l) + g) * n;
	endfunction

	function automatic logic [OUTLET_W-1:0] pick_outlet();
		if ($urandom_range(0, 9) < 8)
			return OUTLET_W'($urandom_range(0, NUM_OUTLETS - 1));
		return OUTLET_W'($urandom_range(NUM_OUTLETS, 7));
	endfunction

	function automatic logic [WIDTH_BITS-1:0] pick_width();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			return '0;
		if (roll < 20)
			return WIDTH_BITS'($urandom_range(3, 12));
		return WIDTH_BITS'($urandom_range(1, 2));
	endfunction

	task automatic queue_item(logic cmd, logic [OUTLET_W-1:0] idx, logic on);
		switch_item_t it;
		it.command = cmd;
		it.outlet = idx;
		it.switch_on = on;
		switch_items.push_back(it);
		queued_total++;
	endtask

	// ticks carry random don't-care fields
	task automatic queue_ticks(int n);
		repeat (n)
			queue_item(CMD_TICK, OUTLET_W'($urandom_range(0, 7)),
				1'($urandom_range(0, 1)));
	endtask

	// all requests in and all results back
	task automatic wait_quiet();
		while (switch_items.size() != 0 || in_valid || pin_results_due.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// caller sits at a rising edge with the block quiet
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WIDTH_BITS-1:0] val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_SHORT:  reg_file.short_width = val;
			REG_LONG:   reg_file.long_width = val;
			REG_GAP:    reg_file.gap_width = val;
			default:    reg_file.repeat_total = val[REP_BITS-1:0];
		endcase
		@(posedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				pin_results_due.push_back(pin_step(offered));
				items_taken++;
			end
			if (!in_valid || in_ready) begin
				if (switch_items.size() != 0 &&
				    ((items_taken >= 500 && items_taken < 700) ||
				     $urandom_range(0, 99) >= 34)) begin
					offered = switch_items.pop_front();
					command <= offered.command;
					outlet <= offered.outlet;
					switch_on <= offered.switch_on;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		result_t due;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_taken++;
				status_seen[request_status]++;
				if (request_status == ST_TICK && busy_res)
					busy_ticks++;
				if (pin_results_due.size() == 0) begin
					errors++;
					$display("%0t unexpected result: pin_level %0b busy_res %0b",
						$time, pin_level, busy_res);
					$display("%0t unexpected result: request_status %0d",
						$time, request_status);
				end else begin
					due = pin_results_due.pop_front();
					if (pin_level !== due.pin_level) begin
						errors++;
						$display("%0t pin_level mismatch: expected %0b actual %0b",
							$time, due.pin_level, pin_level);
					end
					if (busy_res !== due.busy_res) begin
						errors++;
						$display("%0t busy_res mismatch: expected %0b actual %0b",
							$time, due.busy_res, busy_res);
					end
					if (request_status !== due.request_status) begin
						errors++;
						$display("%0t request_status mismatch: expected %0d actual %0d",
							$time, due.request_status, request_status);
					end
				end
			end
			// one long hold-off so the block fills and stalls its input
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (results_taken >= 1000 && !stall_done) begin
				stall_done = 1'b1;
				stall_left = 120;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (results_taken >= 500 && results_taken < 700) ||
					$urandom_range(0, 99) >= 34;
			end
		end
	end

	// stimulus
	initial begin
		int directed_total;
		int n;
		int span;
		reg_file.short_width = SHORT_RST;
		reg_file.long_width = LONG_RST;
		reg_file.gap_width = GAP_RST;
		reg_file.repeat_total = REPEAT_RST;
		for (int i = 0; i < NUM_OUTLETS; i++)
			outlet_level[i] = LEVEL_UNKNOWN;
		word_bits = '0;
		bit_idx = '0;
		words_sent = '0;
		tx_phase = PH_IDLE;
		tx_ticks = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// idle tick, outlet numbers past the last outlet
		queue_ticks(1);
		queue_item(CMD_REQUEST, 3'd5, 1'b1);
		queue_item(CMD_REQUEST, 3'd6, 1'b0);
		queue_item(CMD_REQUEST, 3'd7, 1'b1);
		// unknown state starts under reset timing, a second request is turned away
		queue_item(CMD_REQUEST, 3'd1, 1'b0);
		queue_item(CMD_REQUEST, 3'd2, 1'b1);
		queue_ticks(3);
		wait_quiet();
		// largest register values in the middle of a phase
		write_reg(REG_SHORT, 16'hFFFF);
		write_reg(REG_LONG, 16'hFFFF);
		write_reg(REG_GAP, 16'hFFFF);
		write_reg(REG_REPEAT, 16'h00FF);
		cfg_wen <= 1'b0;
		queue_ticks(3);
		wait_quiet();
		// shrink below the elapsed ticks, zero widths and zero repeat count
		write_reg(REG_SHORT, 16'd1);
		write_reg(REG_LONG, 16'd0);
		write_reg(REG_GAP, 16'd0);
		write_reg(REG_REPEAT, 16'd0);
		cfg_wen <= 1'b0;
		queue_ticks(word_run_ticks() + 4);
		// already in that state, then the opposite level
		queue_item(CMD_REQUEST, 3'd1, 1'b0);
		queue_item(CMD_REQUEST, 3'd1, 1'b1);
		queue_ticks(word_run_ticks() + 4);
		wait_quiet();
		write_reg(REG_SHORT, 16'd2);
		write_reg(REG_LONG, 16'd1);
		write_reg(REG_GAP, 16'd3);
		write_reg(REG_REPEAT, 16'd2);
		cfg_wen <= 1'b0;
		queue_item(CMD_REQUEST, 3'd0, 1'b1);
		queue_ticks(word_run_ticks() + 2);
		queue_item(CMD_REQUEST, 3'd4, 1'b0);
		queue_ticks(10);
		queue_item(CMD_REQUEST, 3'd3, 1'b1);
		queue_ticks(word_run_ticks() + 2);
		directed_total = queued_total;

		// random part: mostly a request followed by enough ticks to finish it
		while (queued_total < directed_total + RANDOM_ITEMS) begin
			if (queued_total < directed_total + 700 && $urandom_range(0, 99) < 35) begin
				wait_quiet();
				if ($urandom_range(0, 1)) write_reg(REG_SHORT, pick_width());
				if ($urandom_range(0, 1)) write_reg(REG_LONG, pick_width());
				if ($urandom_range(0, 1)) write_reg(REG_GAP, pick_width());
				if ($urandom_range(0, 1))
					write_reg(REG_REPEAT, ($urandom_range(0, 9) == 0) ? 16'd0 :
						WIDTH_BITS'($urandom_range(1, 2)));
				cfg_wen <= 1'b0;
			end
			queue_item(CMD_REQUEST, pick_outlet(), 1'($urandom_range(0, 1)));
			span = word_run_ticks();
			n = ($urandom_range(0, 99) < 85) ? span + $urandom_range(0, 8) :
				$urandom_range(0, span);
			for (int k = 0; k < n && queued_total < directed_total + RANDOM_ITEMS; k++) begin
				if ($urandom_range(0, 99) < 3)
					queue_item(CMD_REQUEST, pick_outlet(), 1'($urandom_range(0, 1)));
				else
					queue_ticks(1);
			end
		end

		wait_quiet();
		repeat (4) @(posedge clk);
		$display("covered %0d requests: %0d started, %0d skipped, %0d turned away busy",
			status_seen[ST_STARTED] + status_seen[ST_SKIPPED] +
			status_seen[ST_REJECTED],
			status_seen[ST_STARTED], status_seen[ST_SKIPPED], status_seen[ST_REJECTED]);
		$display("%0d ticks, %0d of them during a transmission, %0d mismatches",
			status_seen[ST_TICK], busy_ticks, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", pin_results_due.size());
		$display("FAIL");
		$finish;
	end

endmodule

### sim.f
rtl/core/rfo_pkg.sv
rtl/core/rfo_cfg_regs.sv
rtl/core/rfo_encoder.sv
rtl/core/rf_outlet_pulse_width_transmitter_top.sv
tb/tb_rf_outlet_pulse_width_transmitter_top.sv
